/* hdl/disparity_select_uniqueness_subpixel_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the disparity select block
// Shared forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef DISPARITY_SELECT_UNIQUENESS_SUBPIXEL_TOP_ASSERT_SVH
`define DISPARITY_SELECT_UNIQUENESS_SUBPIXEL_TOP_ASSERT_SVH

// same-cycle implication
`define DSUS_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("disparity select: check failed");

// next-cycle implication
`define DSUS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("disparity select: check failed");

`endif

/* hdl/dsus_pkg.sv */
// ----------------------------------------------------------------------------
// dsus_pkg
// Types and fixed widths shared by the disparity select block.
// ----------------------------------------------------------------------------
package dsus_pkg;

  localparam int COST_W     = 16;
  localparam logic [COST_W-1:0] COST_MAX = 16'hFFFF;
  localparam int MIN_DISP_W = 9;
  localparam int KEEP_W     = 9;
  localparam int Q_W        = 14;
  localparam int BEST_W     = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DISP_OFFSET   = 2'd0,
    REG_CHECK_UNIQUE  = 2'd1,
    REG_UNIQUE_KEEP   = 2'd2
  } cfg_reg_t;

  // per-pixel summary handed from front to back (index travels beside it)
  typedef struct packed {
    logic              any_taken;
    logic              border;
    logic [COST_W-1:0] low_cost;
    logic [COST_W-1:0] second_cost;
    logic [COST_W-1:0] before_cost;
    logic [COST_W-1:0] after_cost;
  } dsus_summary_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MULT,
    BK_DECIDE,
    BK_DIV,
    BK_DONE
  } bk_state_t;

endpackage

/* hdl/dsus_if.sv */
// ----------------------------------------------------------------------------
// dsus channel interfaces
// Cost input stream, disparity result stream and configuration write channel.
// ----------------------------------------------------------------------------
interface dsus_cost_if import dsus_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [COST_W-1:0] cost;
  logic              last_cost;

  modport source (output valid, cost, last_cost, input ready);
  modport sink   (input valid, cost, last_cost, output ready);
endinterface

interface dsus_disp_if import dsus_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    disp_valid;
  logic signed [Q_W-1:0]   disparity_q4;
  logic signed [BEST_W-1:0] int_disparity;

  modport source (output valid, disp_valid, disparity_q4, int_disparity, input ready);
  modport sink   (input valid, disp_valid, disparity_q4, int_disparity, output ready);
endinterface

interface dsus_cfg_if import dsus_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/disparity_select_uniqueness_subpixel_top.sv */
// Winner-take-all disparity select with uniqueness test and subpixel offset.
// Costs enter one per cycle while the summary queue has room; the
// front tracks the minimum on the fly and hands a summary per pixel to a
// two-entry queue. The back takes each pixel through multiply and decide,
// a divide pass if valid, and a done state that waits for a free output;
// its restoring divider yields one quotient bit per cycle. Runs as long as
// a back pass stream at one cost per cycle, shorter ones at one pixel per
// back pass once the queue is full. Configuration writes are taken every cycle.
// ----------------------------------------------------------------------------
// disparity_select_uniqueness_subpixel_top
// Top level: configuration registers, front tracker, summary queue, back end.
// ----------------------------------------------------------------------------
`include "disparity_select_uniqueness_subpixel_top_assert.svh"

module disparity_select_uniqueness_subpixel_top import dsus_pkg::*; #(
  parameter int MAX_DISPARITIES = 128,
  parameter int FRAC_BITS       = 4
) (
  input  logic        clk,
  input  logic        rst,
  dsus_cfg_if.sink    cfg,
  dsus_cost_if.sink   cost_stream,
  dsus_disp_if.source disp_stream
);

  localparam int IDX_W = $clog2(MAX_DISPARITIES);
  localparam int CNT_W = $clog2(MAX_DISPARITIES + 1);
  localparam int SUM_W = $bits(dsus_summary_t) + IDX_W;

  logic signed [MIN_DISP_W-1:0] disp_offset;
  logic                         check_unique;
  logic [KEEP_W-1:0]            uniqueness_keep_q8;

  logic                push;
  logic                pop;
  logic                q_full;
  logic                q_empty;
  dsus_summary_t       front_summary;
  logic [IDX_W-1:0]    front_index;
  dsus_summary_t       back_summary;
  logic [IDX_W-1:0]    back_index;
  logic [SUM_W-1:0]    q_rd_data;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      disp_offset        <= '0;
      check_unique       <= 1'b1;
      uniqueness_keep_q8 <= KEEP_W'(13);
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_DISP_OFFSET:   disp_offset        <= $signed(cfg.data[MIN_DISP_W-1:0]);
        REG_CHECK_UNIQUE:  check_unique       <= cfg.data[0];
        REG_UNIQUE_KEEP:   uniqueness_keep_q8 <= cfg.data[KEEP_W-1:0];
        default:           check_unique       <= check_unique;
      endcase
    end
  end

  dsus_front #(
    .MAX_DISPARITIES (MAX_DISPARITIES),
    .IDX_W           (IDX_W),
    .CNT_W           (CNT_W)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cost_stream   (cost_stream),
    .full          (q_full),
    .push          (push),
    .summary       (front_summary),
    .summary_index (front_index)
  );

  dsus_fifo #(
    .WIDTH (SUM_W),
    .DEPTH (2)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data ({front_summary, front_index}),
    .pop     (pop),
    .rd_data (q_rd_data),
    .full    (q_full),
    .empty   (q_empty)
  );

  assign back_summary = q_rd_data[SUM_W-1:IDX_W];
  assign back_index   = q_rd_data[IDX_W-1:0];

  dsus_back #(
    .IDX_W     (IDX_W),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk                (clk),
    .rst                (rst),
    .empty              (q_empty),
    .summary            (back_summary),
    .summary_index      (back_index),
    .pop                (pop),
    .disp_offset        (disp_offset),
    .check_unique       (check_unique),
    .uniqueness_keep_q8 (uniqueness_keep_q8),
    .disp_stream        (disp_stream)
  );

  // an invalid pixel never carries a subpixel value
  `DSUS_ASSERT_IMPLIES(a_invalid_zero_q, clk, rst, disp_stream.valid && !disp_stream.disp_valid, disp_stream.disparity_q4 == '0)
  // a summary pushed without a pop must be waiting in the queue next cycle
  `DSUS_ASSERT_NEXT(a_queue_holds_push, clk, rst, push && !pop, !q_empty)
  // the back never pops while the queue is empty
  `DSUS_ASSERT_IMPLIES(a_pop_needs_data, clk, rst, pop, !q_empty)

endmodule

/* hdl/dsus_front.sv */
// ----------------------------------------------------------------------------
// dsus_front
// Takes one cost a cycle unless the queue is full, tracks minimum, second
// minimum and best-index neighbor costs, and pushes a pixel summary on the last cost.
// ----------------------------------------------------------------------------
module dsus_front import dsus_pkg::*; #(
  parameter int MAX_DISPARITIES = 128,
  parameter int IDX_W           = 7,
  parameter int CNT_W           = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  dsus_cost_if.sink            cost_stream,
  input  logic                 full,
  output logic                 push,
  output dsus_summary_t        summary,
  output logic [IDX_W-1:0]     summary_index
);

  logic [COST_W-1:0] min_seen, min_seen_next;
  logic [COST_W-1:0] second_seen, second_seen_next;
  logic [IDX_W-1:0]  best_index, best_index_next;
  logic [COST_W-1:0] previous_cost, previous_cost_next;
  logic [COST_W-1:0] cost_before_best, cost_before_best_next;
  logic [COST_W-1:0] cost_after_best, cost_after_best_next;
  logic              awaiting_after, awaiting_after_next;
  logic [CNT_W-1:0]  cost_index, cost_index_next;
  logic              any_taken, any_taken_next;
  logic [CNT_W-1:0]  last_idx;
  logic              take;

  assign cost_stream.ready = !full;
  assign take = cost_stream.valid && cost_stream.ready;
  assign push = take && cost_stream.last_cost;

  always_comb begin
    min_seen_next         = min_seen;
    second_seen_next      = second_seen;
    best_index_next       = best_index;
    previous_cost_next    = previous_cost;
    cost_before_best_next = cost_before_best;
    cost_after_best_next  = cost_after_best;
    awaiting_after_next   = awaiting_after;
    cost_index_next       = cost_index;
    any_taken_next        = any_taken;
    // drop costs past the end of the range, but keep their last flag
    if (cost_index < CNT_W'(MAX_DISPARITIES)) begin
      if (awaiting_after) begin
        cost_after_best_next = cost_stream.cost;
        awaiting_after_next  = 1'b0;
      end
      if (cost_stream.cost < min_seen) begin
        second_seen_next      = min_seen;
        min_seen_next         = cost_stream.cost;
        best_index_next       = cost_index[IDX_W-1:0];
        cost_before_best_next = (cost_index == '0) ? COST_MAX : previous_cost;
        cost_after_best_next  = COST_MAX;
        awaiting_after_next   = 1'b1;
        any_taken_next        = 1'b1;
      end else if (cost_stream.cost < second_seen) begin
        second_seen_next = cost_stream.cost;
      end
      previous_cost_next = cost_stream.cost;
      cost_index_next    = cost_index + CNT_W'(1);
    end
  end

  assign last_idx = (cost_index_next == '0) ? '0 : cost_index_next - CNT_W'(1);

  always_comb begin
    summary.any_taken   = any_taken_next;
    summary.border      = (best_index_next == '0) ||
                          (CNT_W'(best_index_next) == last_idx);
    summary.low_cost    = min_seen_next;
    summary.second_cost = second_seen_next;
    summary.before_cost = cost_before_best_next;
    summary.after_cost  = cost_after_best_next;
    summary_index       = best_index_next;
  end

  always_ff @(posedge clk) begin
    if (rst || push) begin
      min_seen         <= COST_MAX;
      second_seen      <= COST_MAX;
      best_index       <= '0;
      previous_cost    <= COST_MAX;
      cost_before_best <= COST_MAX;
      cost_after_best  <= COST_MAX;
      awaiting_after   <= 1'b0;
      cost_index       <= '0;
      any_taken        <= 1'b0;
    end else if (take) begin
      min_seen         <= min_seen_next;
      second_seen      <= second_seen_next;
      best_index       <= best_index_next;
      previous_cost    <= previous_cost_next;
      cost_before_best <= cost_before_best_next;
      cost_after_best  <= cost_after_best_next;
      awaiting_after   <= awaiting_after_next;
      cost_index       <= cost_index_next;
      any_taken        <= any_taken_next;
    end
  end

endmodule

/* hdl/dsus_fifo.sv */
// ----------------------------------------------------------------------------
// dsus_fifo
// Short register queue of pixel summaries between front and back.
// ----------------------------------------------------------------------------
module dsus_fifo import dsus_pkg::*; #(
  parameter int WIDTH = 73,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

/* hdl/dsus_back.sv */
// ----------------------------------------------------------------------------
// dsus_back
// Per-pixel decision: uniqueness and border tests, then the subpixel offset
// through a restoring divider that settles one quotient bit a cycle.
// ----------------------------------------------------------------------------
module dsus_back import dsus_pkg::*; #(
  parameter int IDX_W     = 7,
  parameter int FRAC_BITS = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         empty,
  input  dsus_summary_t                summary,
  input  logic [IDX_W-1:0]             summary_index,
  output logic                         pop,
  input  logic signed [MIN_DISP_W-1:0] disp_offset,
  input  logic                         check_unique,
  input  logic [KEEP_W-1:0]            uniqueness_keep_q8,
  dsus_disp_if.source                  disp_stream
);

  localparam int BW_BASE = (IDX_W + 1 > MIN_DISP_W) ? IDX_W + 1 : MIN_DISP_W;
  localparam int BW      = BW_BASE + 1;
  localparam int QF_BASE = BW + FRAC_BITS + 1;
  localparam int QFW     = (QF_BASE > Q_W) ? QF_BASE : Q_W;
  localparam int NUM_W   = COST_W + FRAC_BITS;
  localparam int DEN_W   = COST_W + 2;
  localparam int PROD_W  = COST_W + KEEP_W;
  localparam int DCNT_W  = (NUM_W > 1) ? $clog2(NUM_W) : 1;

  bk_state_t state, state_next;

  dsus_summary_t            sum_r;
  logic [IDX_W-1:0]         index_r;
  logic [PROD_W-1:0]        prod;
  logic signed [BW-1:0]     best_full;
  logic                     diff_neg;
  logic [NUM_W-1:0]         num;
  logic [DEN_W-1:0]         divisor;
  logic [DEN_W-1:0]         rem;
  logic [DCNT_W-1:0]        div_count;
  logic                     pix_valid;

  logic                     out_valid;
  logic                     out_disp_valid;
  logic signed [Q_W-1:0]    out_q;
  logic signed [BEST_W-1:0] out_best;

  logic                     load_out;
  logic                     decide_valid;
  logic                     div_last;
  logic [COST_W:0]          neigh_sum;
  logic signed [COST_W+1:0] den_s;
  logic [COST_W-1:0]        diff_mag;
  logic [DEN_W:0]           trial;
  logic                     trial_ge;
  logic signed [QFW-1:0]    q_frac;
  logic signed [QFW-1:0]    q_full;

  // ---- datapath combinational terms
  assign neigh_sum = {1'b0, sum_r.before_cost} + {1'b0, sum_r.after_cost};
  assign den_s     = $signed({1'b0, neigh_sum}) - $signed({1'b0, sum_r.low_cost, 1'b0});
  assign diff_mag  = (sum_r.before_cost >= sum_r.after_cost) ?
                     sum_r.before_cost - sum_r.after_cost :
                     sum_r.after_cost - sum_r.before_cost;

  assign decide_valid = sum_r.any_taken && !sum_r.border &&
                        !(check_unique &&
                          ({1'b0, sum_r.second_cost - sum_r.low_cost} <= prod[PROD_W-1:8]));

  assign trial    = {rem, num[NUM_W-1]};
  assign trial_ge = (trial >= {1'b0, divisor});
  assign div_last = (div_count == DCNT_W'(NUM_W - 1));

  // quotient magnitude is at most half an integer step, so it fits QFW
  assign q_frac = $signed(QFW'(num));
  assign q_full = (QFW'(best_full) <<< FRAC_BITS) + (diff_neg ? -q_frac : q_frac);

  // ---- next state
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE:   if (!empty) state_next = BK_MULT;
      BK_MULT:   state_next = BK_DECIDE;
      BK_DECIDE: state_next = decide_valid ? BK_DIV : BK_DONE;
      BK_DIV:    if (div_last) state_next = BK_DONE;
      BK_DONE:   if (!out_valid || disp_stream.ready) state_next = BK_IDLE;
      default:   state_next = BK_IDLE;
    endcase
  end

  // ---- control outputs
  always_comb begin
    pop      = 1'b0;
    load_out = 1'b0;
    case (state)
      BK_IDLE: pop      = !empty;
      BK_DONE: load_out = !out_valid || disp_stream.ready;
      default: begin
        pop      = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---- datapath registers
  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        if (!empty) begin
          sum_r   <= summary;
          index_r <= summary_index;
        end
      end
      BK_MULT: begin
        prod      <= PROD_W'(sum_r.low_cost) * PROD_W'(uniqueness_keep_q8);
        best_full <= BW'(disp_offset) + $signed({{(BW - IDX_W){1'b0}}, index_r});
        diff_neg  <= sum_r.before_cost < sum_r.after_cost;
        num       <= {diff_mag, {FRAC_BITS{1'b0}}};
        divisor   <= (den_s < $signed((COST_W + 2)'(1))) ?
                     DEN_W'(2) : {den_s[COST_W:0], 1'b0};
      end
      BK_DECIDE: begin
        pix_valid <= decide_valid;
        rem       <= '0;
        div_count <= '0;
      end
      BK_DIV: begin
        // shift in one quotient bit, subtract when the trial fits
        rem       <= trial_ge ? DEN_W'(trial - {1'b0, divisor}) : trial[DEN_W-1:0];
        num       <= {num[NUM_W-2:0], trial_ge};
        div_count <= div_count + DCNT_W'(1);
      end
      default: begin
        pix_valid <= pix_valid;
      end
    endcase
  end

  // ---- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (disp_stream.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_disp_valid <= pix_valid;
      out_q          <= pix_valid ? q_full[Q_W-1:0] : '0;
      out_best       <= sum_r.any_taken ? best_full[BEST_W-1:0] : '0;
    end
  end

  assign disp_stream.valid         = out_valid;
  assign disp_stream.disp_valid    = out_disp_valid;
  assign disp_stream.disparity_q4  = out_q;
  assign disp_stream.int_disparity = out_best;

endmodule
